// ===== rtl/core/stg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stg_pkg: shared constants, widths and sine table for the tone generator
// Holds the field widths, register index codes, datapath widths of the serial
// multiplier and divider, and the quarter-wave sine table built at elaboration.
// ----------------------------------------------------------------------------
package stg_pkg;

  // Oscillator geometry
  localparam int PHASE_BITS   = 32;
  localparam int TABLE_BITS   = 10;
  localparam int QUARTER_BITS = TABLE_BITS - 2;
  localparam int QUARTER      = 1 << QUARTER_BITS;
  localparam int ROM_IDX_W    = QUARTER_BITS + 1;

  // Field widths
  localparam int STEP_W   = 32;
  localparam int FRAME_W  = 24;
  localparam int FADE_W   = 16;
  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTE_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_NOMINAL = 2'd2;

  // Scaling: sample = mag * 30000 * num / (2^15 * den)
  localparam int AMP_SHIFT = 15;
  localparam int MUL_A_W   = MAG_W + 15;
  localparam int MUL_B_W   = FADE_W;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam logic [MUL_A_W-1:0] AMPLITUDE = MUL_A_W'(30000);

  // Divider: quotient never exceeds 30000, so AMP_SHIFT bits suffice
  localparam int DIV_N_W = PROD_W - AMP_SHIFT;
  localparam int DIV_Q_W = AMP_SHIFT;
  localparam int DIV_R_W = DIV_N_W - DIV_Q_W;
  localparam int DIV_D_W = FADE_W;

  // Polynomial coefficients of sin(pi/2 * u), Q30
  localparam logic [63:0] COEF_A1 = 64'd1686629713;
  localparam logic [63:0] COEF_A3 = 64'd693598668;
  localparam logic [63:0] COEF_A5 = 64'd85569306;
  localparam logic [63:0] COEF_A7 = 64'd5026995;
  localparam logic [63:0] COEF_A9 = 64'd172272;

  typedef logic [MAG_W-1:0] sine_rom_t [0:QUARTER];

  // Evaluate the polynomial once per entry, truncating each product to Q30.
  function automatic sine_rom_t sine_rom_build();
    sine_rom_t   rom;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] p;
    for (int m = 0; m <= QUARTER; m++) begin
      u   = 64'(m) << (30 - QUARTER_BITS);
      u2  = (u * u) >> 30;
      p   = COEF_A7 - ((u2 * COEF_A9) >> 30);
      p   = COEF_A5 - ((u2 * p) >> 30);
      p   = COEF_A3 - ((u2 * p) >> 30);
      p   = COEF_A1 - ((u2 * p) >> 30);
      p   = (u * p) >> 30;
      rom[m] = MAG_W'((p + 64'd16384) >> 15);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = sine_rom_build();

endpackage

// ===== rtl/core/stg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stg_if: tick and frame channels of the tone generator
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface stg_in_if import stg_pkg::*;;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface stg_out_if import stg_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;
  logic                       last_frame;
  logic                       silent;

  modport source (output valid, output left_sample, output right_sample,
                  output last_frame, output silent, input ready);
  modport sink (input valid, input left_sample, input right_sample,
                input last_frame, input silent, output ready);
endinterface

// ===== rtl/core/stg_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stg_mul: bit-serial shift-add multiplier
// Consumes one multiplier bit per cycle; product is valid when done pulses.
// ----------------------------------------------------------------------------
module stg_mul import stg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [MUL_A_W-1:0] mul_a,
  input  logic [MUL_B_W-1:0] mul_b,
  output logic               done,
  output logic [PROD_W-1:0]  product
);

  localparam int CNT_W = $clog2(MUL_B_W);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [MUL_A_W-1:0] a_r, a_nxt;
  logic [PROD_W:0]    prod_r, prod_nxt;
  logic [MUL_A_W+1:0] sum;

  // Add the multiplicand into the upper half when the low bit is set.
  assign sum = {1'b0, prod_r[PROD_W:MUL_B_W]} +
               (prod_r[0] ? {2'b00, a_r} : '0);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    prod_nxt = prod_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(MUL_B_W - 1);
      a_nxt    = mul_a;
      prod_nxt = {(PROD_W + 1 - MUL_B_W)'(0), mul_b};
    end else if (busy_r) begin
      prod_nxt = {sum, prod_r[MUL_B_W-1:1]};
      cnt_nxt  = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    a_r    <= a_nxt;
    prod_r <= prod_nxt;
  end

  assign done    = done_r;
  assign product = prod_r[PROD_W-1:0];

endmodule

// ===== rtl/core/stg_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stg_div: bit-serial restoring divider
// Produces one quotient bit per cycle; the caller guarantees that the quotient
// fits DIV_Q_W bits, so the upper dividend bits seed the partial remainder.
// ----------------------------------------------------------------------------
module stg_div import stg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output logic               done,
  output logic [DIV_Q_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_Q_W);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DIV_D_W-1:0] den_r, den_nxt;
  logic [DIV_R_W-1:0] rem_r, rem_nxt;
  logic [DIV_Q_W-1:0] work_r, work_nxt;
  logic [DIV_R_W:0]   trial;
  logic               fits;

  // Bring down the next dividend bit and try a subtract.
  assign trial = {rem_r, work_r[DIV_Q_W-1]};
  assign fits  = trial >= (DIV_R_W + 1)'(den_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    work_nxt = work_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIV_Q_W - 1);
      den_nxt  = divisor;
      rem_nxt  = dividend[DIV_N_W-1:DIV_Q_W];
      work_nxt = dividend[DIV_Q_W-1:0];
    end else if (busy_r) begin
      rem_nxt  = fits ? DIV_R_W'(trial - (DIV_R_W + 1)'(den_r)) : DIV_R_W'(trial);
      work_nxt = {work_r[DIV_Q_W-2:0], fits};
      cnt_nxt  = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    work_r <= work_nxt;
  end

  assign done     = done_r;
  assign quotient = work_r;

endmodule

// ===== rtl/core/sine_tone_generator_with_fade.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_tone_generator_with_fade: DDS sine oscillator with linear fade
// One stereo frame per tick: a phase accumulator addresses a quarter-wave
// sine table, the sample is scaled by 30000 and a fade-in/fade-out envelope
// through a bit-serial multiplier and divider, and truncated toward zero.
//
//   channel   dir   handshake       transaction
//   in_chan   in    valid/ready     one tick, restart flag
//   out_chan  out   valid/ready     one stereo frame plus last/silent flags
//   cfg_*     in    write enable    one register write, no read-back
//
// A tone frame reaches the output register through the setup state, the
// envelope state, the serial multiplier (16 envelope bits, one per cycle),
// the serial divider (15 quotient bits) and the output load. Ready returns
// the cycle after, so a new tone tick is taken only once the previous frame
// has been loaded. A tick after the note has ended skips the envelope,
// multiplier and divider and goes from setup straight to the output load.
// Synchronous active-low reset clears state, phase, frame count, output valid
// and the configuration registers. A new tick is accepted while the previous
// frame waits in the output register; a full output register stalls only the final load.
// ----------------------------------------------------------------------------
module sine_tone_generator_with_fade import stg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  stg_in_if.sink                in_chan,
  stg_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SETUP = 6'b000010,
    S_ENV   = 6'b000100,
    S_MUL   = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [STEP_W-1:0]  phase_step_r;
  logic [FRAME_W-1:0] note_length_r;
  logic [FADE_W-1:0]  fade_nominal_r;

  // Oscillator state
  logic [PHASE_BITS-1:0] phase_acc_r, phase_acc_nxt;
  logic [FRAME_W-1:0]    frame_r, frame_nxt;

  // Per-frame working registers
  logic [FRAME_W-1:0]    idx_r, idx_nxt;
  logic [FRAME_W-1:0]    left_frames_r, left_frames_nxt;
  logic [TABLE_BITS-1:0] addr_r, addr_nxt;
  logic [FADE_W-1:0]     fade_r, fade_nxt;
  logic [FADE_W-1:0]     den_r, den_nxt;
  logic [MAG_W-1:0]      mag_r, mag_nxt;
  logic                  neg_r, neg_nxt;
  logic                  last_r, last_nxt;
  logic                  silent_r, silent_nxt;

  // Output register
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_silent_r, out_silent_nxt;

  logic                    in_fire;
  logic [PHASE_BITS-1:0]   base_phase;
  logic [FRAME_W-1:0]      base_frame;
  logic [FRAME_W:0]        frames_diff;
  logic                    active;
  logic                    fade_over;
  logic [FADE_W-1:0]       fade_eff;
  logic [ROM_IDX_W-1:0]    rom_idx;
  logic                    fade_in;
  logic                    fade_out;
  logic [FADE_W-1:0]       num;
  logic                    out_free;
  logic [SAMPLE_W-1:0]     mag_s;

  logic                    mul_start;
  logic [MUL_A_W-1:0]      mul_a;
  logic                    mul_done;
  logic [PROD_W-1:0]       product;
  logic                    div_start;
  logic                    div_done;
  logic [DIV_Q_W-1:0]      quotient;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid & in_chan.ready;

  // Restart clears phase and frame before this tick is evaluated.
  assign base_phase = in_chan.restart ? '0 : phase_acc_r;
  assign base_frame = in_chan.restart ? '0 : frame_r;

  // Frames left after this one; a borrow means the note has ended.
  assign frames_diff = {1'b0, note_length_r} - {1'b0, idx_r} - (FRAME_W + 1)'(1);
  assign active      = !frames_diff[FRAME_W];

  // Shrink the fade to a quarter note when it exceeds half the note.
  assign fade_over = (FRAME_W'(fade_nominal_r) > (note_length_r >> 1));
  assign fade_eff  = fade_over ? FADE_W'(note_length_r >> 2) : fade_nominal_r;

  // Odd quadrants read the quarter wave backwards.
  assign rom_idx = addr_r[TABLE_BITS-2] ?
                   (ROM_IDX_W'(QUARTER) - {1'b0, addr_r[QUARTER_BITS-1:0]}) :
                   {1'b0, addr_r[QUARTER_BITS-1:0]};

  // Fade-in below the fade length; fade-out once frames left + 1 < fade.
  assign fade_in  = (idx_r < FRAME_W'(fade_r));
  assign fade_out = (({1'b0, left_frames_r} + (FRAME_W + 1)'(1)) <
                     (FRAME_W + 1)'(fade_r));
  assign num      = fade_in  ? FADE_W'(idx_r) :
                    fade_out ? FADE_W'(left_frames_r) : FADE_W'(1);

  assign mul_start = (state_r == S_ENV);
  assign mul_a     = MUL_A_W'(mag_r) * AMPLITUDE;
  assign div_start = (state_r == S_MUL) && mul_done;

  assign out_free = !out_valid_r || out_chan.ready;
  assign mag_s    = {1'b0, quotient};

  stg_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mul_a   (mul_a),
    .mul_b   (num),
    .done    (mul_done),
    .product (product)
  );

  stg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (product[PROD_W-1:AMP_SHIFT]),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_nxt       = state_r;
    phase_acc_nxt   = phase_acc_r;
    frame_nxt       = frame_r;
    idx_nxt         = idx_r;
    left_frames_nxt = left_frames_r;
    addr_nxt        = addr_r;
    fade_nxt        = fade_r;
    den_nxt         = den_r;
    mag_nxt         = mag_r;
    neg_nxt         = neg_r;
    last_nxt        = last_r;
    silent_nxt      = silent_r;
    out_valid_nxt   = out_valid_r;
    out_sample_nxt  = out_sample_r;
    out_last_nxt    = out_last_r;
    out_silent_nxt  = out_silent_r;

    // Drop the output frame once it is taken.
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          idx_nxt       = base_frame;
          addr_nxt      = base_phase[PHASE_BITS-1 -: TABLE_BITS];
          phase_acc_nxt = base_phase;
          frame_nxt     = base_frame;
          state_nxt     = S_SETUP;
        end
      end
      S_SETUP: begin
        left_frames_nxt = frames_diff[FRAME_W-1:0];
        fade_nxt        = fade_eff;
        mag_nxt         = SINE_ROM[rom_idx];
        neg_nxt         = addr_r[TABLE_BITS-1];
        last_nxt        = (frames_diff[FRAME_W-1:0] == '0);
        silent_nxt      = !active;
        if (active) begin
          // Advance the oscillator for the next tick.
          phase_acc_nxt = phase_acc_r + PHASE_BITS'(phase_step_r);
          frame_nxt     = idx_r + FRAME_W'(1);
          state_nxt     = S_ENV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_ENV: begin
        den_nxt   = (fade_in || fade_out) ? fade_r : FADE_W'(1);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (mul_done) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = silent_r ? '0 : (neg_r ? -mag_s : mag_s);
          out_last_nxt   = !silent_r && last_r;
          out_silent_nxt = silent_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      phase_acc_r    <= '0;
      frame_r        <= '0;
      out_valid_r    <= 1'b0;
      phase_step_r   <= '0;
      note_length_r  <= '0;
      fade_nominal_r <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_acc_r <= phase_acc_nxt;
      frame_r     <= frame_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PHASE_STEP:   phase_step_r   <= cfg_data[STEP_W-1:0];
          CFG_NOTE_LENGTH:  note_length_r  <= cfg_data[FRAME_W-1:0];
          CFG_FADE_NOMINAL: fade_nominal_r <= cfg_data[FADE_W-1:0];
          default: begin
          end
        endcase
      end
    end
    idx_r         <= idx_nxt;
    left_frames_r <= left_frames_nxt;
    addr_r        <= addr_nxt;
    fade_r        <= fade_nxt;
    den_r         <= den_nxt;
    mag_r         <= mag_nxt;
    neg_r         <= neg_nxt;
    last_r        <= last_nxt;
    silent_r      <= silent_nxt;
    out_sample_r  <= out_sample_nxt;
    out_last_r    <= out_last_nxt;
    out_silent_r  <= out_silent_nxt;
  end

  // Left and right carry the same sample.
  assign out_chan.valid        = out_valid_r;
  assign out_chan.left_sample  = out_sample_r;
  assign out_chan.right_sample = out_sample_r;
  assign out_chan.last_frame   = out_last_r;
  assign out_chan.silent       = out_silent_r;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the faded sine tone generator
// Sends ticks with random restart flags over valid/ready, predicts every
// stereo frame (phase accumulator, quarter-wave sine, linear fade, silence
// after the note) and compares each output transaction in order. Register
// settings change between phases, only once all frames have drained.
// ----------------------------------------------------------------------------
module testbench;
  import stg_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int RESET_LEN   = 9;
  localparam int LIMIT       = 400000;
  localparam int TAIL_CYCLES = 64;
  localparam int LONG_HOLD   = 300;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 155;
  localparam int DIR_ROWS    = 25;
  localparam longint unsigned TONE_AMP = 30000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_smp;
    logic signed [SAMPLE_W-1:0] right_smp;
    logic                       last;
    logic                       silent;
  } frame_t;

  // One directed tick; load rows drain the pipe and rewrite all registers
  // first. Typed rows carry their frame; the rest go to the predictor.
  typedef struct packed {
    logic                       load;
    logic [31:0]                step;
    logic [31:0]                len;
    logic [31:0]                fade;
    logic                       restart;
    logic                       typed;
    logic signed [SAMPLE_W-1:0] smp;
    logic                       last;
    logic                       silent;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  stg_in_if  in_if ();
  stg_out_if out_if ();

  sine_tone_generator_with_fade dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of registers and oscillator state
  logic [STEP_W-1:0]     step_reg;
  logic [FRAME_W-1:0]    len_reg;
  logic [FADE_W-1:0]     fade_reg;
  logic [PHASE_BITS-1:0] tone_phase;
  logic [FRAME_W-1:0]    tone_frame;

  frame_t pending_frames [$];

  int  mismatches   = 0;
  int  tone_cnt     = 0;
  int  silent_cnt   = 0;
  int  note_end_cnt = 0;
  int  setting_cnt  = 0;
  int  tick_cnt     = 0;
  int  cycle_count  = 0;
  int  src_idle_pct = 0;
  int  snk_stall_pct = 0;
  logic hold_tog;

  dir_row_t dir_table [DIR_ROWS] = '{
    // after reset the note is empty: silence
    '{1'b0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 16'sd0, 1'b0, 1'b1},
    // restart into an empty note: still silence
    '{1'b0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1, 16'sd0, 1'b0, 1'b1},
    // one-frame note at phase zero: zero sample, last frame
    '{1'b1, 32'h0, 32'h1, 32'h0, 1'b1, 1'b1, 16'sd0, 1'b1, 1'b0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 16'sd0, 1'b0, 1'b1},
    // quarter-turn steps with zero fade: one tick per quadrant
    '{1'b1, 32'h4000_0000, 32'h4, 32'h0, 1'b1, 1'b1, 16'sd0, 1'b0, 1'b0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 16'sd0, 1'b0, 1'b1},
    // fade longer than half the note shrinks to a quarter; frame 0 is muted
    '{1'b1, 32'h1234_5679, 32'd10, 32'd6, 1'b1, 1'b1, 16'sd0, 1'b0, 1'b0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
    // frame N - f sits at full level, outside the fade-out
    '{1'b0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
    // final frame: fade-out has reached zero
    '{1'b0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 16'sd0, 1'b1, 1'b0},
    // all registers at their maximum; fade-in starts from zero
    '{1'b1, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h0000_FFFF, 1'b1, 1'b1,
      16'sd0, 1'b0, 1'b0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0},
    // restart in the middle of a note: back to frame 0, phase 0
    '{1'b0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1, 16'sd0, 1'b0, 1'b0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0}
  };

  // Q15 quarter-wave magnitude at table step m, odd polynomial in Q30
  function automatic logic [MAG_W-1:0] quarter_mag(input int unsigned m);
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] p;
    u  = 64'(m) << (30 - QUARTER_BITS);
    u2 = (u * u) >> 30;
    p  = COEF_A7 - ((u2 * COEF_A9) >> 30);
    p  = COEF_A5 - ((u2 * p) >> 30);
    p  = COEF_A3 - ((u2 * p) >> 30);
    p  = COEF_A1 - ((u2 * p) >> 30);
    p  = (u * p) >> 30;
    return MAG_W'((p + 64'd16384) >> 15);
  endfunction

  // Work out the frame one tick produces and advance the oscillator state.
  function automatic frame_t predict_frame(input logic restart);
    frame_t                r;
    logic [63:0]           n;
    logic [63:0]           f;
    logic [63:0]           i;
    logic [63:0]           num;
    logic [63:0]           den;
    logic [63:0]           val;
    logic [TABLE_BITS-1:0] addr;
    logic [1:0]            quad;
    int unsigned           k;
    logic [MAG_W-1:0]      mag;
    if (restart) begin
      tone_frame = '0;
      tone_phase = '0;
    end
    n = 64'(len_reg);
    f = 64'(fade_reg);
    i = 64'(tone_frame);
    r = '0;
    if (i >= n) begin
      // note over: silence, state holds
      r.silent = 1'b1;
      return r;
    end
    if (f > n / 2) f = n / 4;
    num = 64'd1;
    den = 64'd1;
    if (i < f) begin
      num = i;
      den = f;
    end else if (f != 0 && i > n - f) begin
      num = n - 1 - i;
      den = f;
    end
    addr = TABLE_BITS'(tone_phase >> (PHASE_BITS - TABLE_BITS));
    quad = addr[TABLE_BITS-1 -: 2];
    k    = int'(addr[QUARTER_BITS-1:0]);
    mag  = quad[0] ? quarter_mag(QUARTER - k) : quarter_mag(k);
    val  = (64'(mag) * TONE_AMP * num) / (64'd32768 * den);
    r.left_smp  = quad[1] ? SAMPLE_W'(64'd0 - val) : SAMPLE_W'(val);
    r.right_smp = r.left_smp;
    r.last      = (i == n - 1);
    tone_phase  = tone_phase + step_reg;
    tone_frame  = FRAME_W'(i + 1);
    return r;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Cycle counter: end the run if the pipe never drains
  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d frames outstanding", $time,
             cycle_count, pending_frames.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: random stalls per cycle, plus a long hold-off on request,
  // counted here so the sender keeps pushing while the output is blocked.
  initial begin : receiver
    int   hold_left;
    logic hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_tog !== hold_seen) begin
        hold_seen = hold_tog;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare each output transaction with the oldest predicted frame.
  always @(posedge clk) begin : frame_monitor
    frame_t want;
    frame_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.left_smp  = out_if.left_sample;
      got.right_smp = out_if.right_sample;
      got.last      = out_if.last_frame;
      got.silent    = out_if.silent;
      if (pending_frames.size() == 0) begin
        $display("%0t: frame with nothing expected: left %0d right %0d last %0b silent %0b",
                 $time, got.left_smp, got.right_smp, got.last, got.silent);
        mismatches++;
      end else begin
        want = pending_frames.pop_front();
        check_field("left_sample", want.left_smp, got.left_smp);
        check_field("right_sample", want.right_smp, got.right_smp);
        check_field("last_frame", want.last, got.last);
        check_field("silent", want.silent, got.silent);
        if (want.silent) silent_cnt++;
        else tone_cnt++;
        if (want.last) note_end_cnt++;
      end
    end
  end

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        src_idle_pct  = 0;
        snk_stall_pct = 0;
      end
      IDLE_SRC: begin
        src_idle_pct  = 60;
        snk_stall_pct = 0;
      end
      IDLE_SNK: begin
        src_idle_pct  = 0;
        snk_stall_pct = 60;
      end
      default: begin
        src_idle_pct  = 28;
        snk_stall_pct = 28;
      end
    endcase
  endtask

  // Offer one tick, hold it until accepted, then queue its frame.
  task automatic send_tick(input logic restart, input logic typed,
                           input frame_t typed_frame);
    frame_t predicted;
    if ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_if.valid   <= 1'b1;
    in_if.restart <= restart;
    do @(posedge clk); while (!in_if.ready);
    predicted = predict_frame(restart);
    pending_frames.push_back(typed ? typed_frame : predicted);
    tick_cnt++;
  endtask

  // Drop valid and wait until every queued frame has come out.
  task automatic drain_frames();
    in_if.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_PHASE_STEP:   step_reg = val;
      CFG_NOTE_LENGTH:  len_reg  = val[FRAME_W-1:0];
      CFG_FADE_NOMINAL: fade_reg = val[FADE_W-1:0];
      default: ;
    endcase
  endtask

  // Reprogram with the block idle; the unused index must change nothing.
  task automatic load_regs(input logic [31:0] step, input logic [31:0] len,
                           input logic [31:0] fade);
    drain_frames();
    write_reg(CFG_PHASE_STEP, step);
    write_reg(CFG_NOTE_LENGTH, len);
    write_reg(CFG_UNUSED, $urandom);
    write_reg(CFG_FADE_NOMINAL, fade);
    cfg_we <= 1'b0;
    setting_cnt++;
  endtask

  initial begin : stimulus
    dir_row_t    row;
    frame_t      typed_frame;
    logic        restart;
    logic [31:0] step;
    logic [31:0] len;
    logic [31:0] fade;

    // Drive every input known from time zero and hold reset.
    rst_n         <= 1'b0;
    hold_tog      <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.restart <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    step_reg      = '0;
    len_reg       = '0;
    fade_reg      = '0;
    tone_phase    = '0;
    tone_frame    = '0;
    repeat (RESET_LEN) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: reset state, extremes and the fade corner cases.
    set_idle(IDLE_BOTH);
    foreach (dir_table[r]) begin
      row = dir_table[r];
      if (row.load) load_regs(row.step, row.len, row.fade);
      typed_frame = '{row.smp, row.smp, row.last, row.silent};
      send_tick(row.restart, row.typed, typed_frame);
    end

    // Random phases: one register setting and one idle pattern each.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          step = $urandom;
          len  = 32'd24;
          fade = 32'd4;
        end
        1: begin
          step = 32'hFFFF_FFFF;
          len  = 32'hFFFF_FFFF;
          fade = 32'hFFFF_FFFF;
        end
        2: begin
          step = 32'h0100_0000;
          len  = 32'd40;
          fade = 32'd0;
        end
        3: begin
          step = 32'd0;
          len  = {8'($urandom), 24'($urandom_range(1, 96))};
          fade = {16'($urandom), 16'($urandom_range(0, 60))};
        end
        default: begin
          // junk above the field width must be masked off
          step = $urandom;
          len  = {8'($urandom), 24'($urandom_range(0, 96))};
          fade = {16'($urandom), 16'($urandom_range(0, 60))};
        end
      endcase
      load_regs(step, len, fade);
      set_idle(idle_mode_e'(ph % 4));
      // Block the output for a long stretch while ticks keep coming.
      if (ph == 4) hold_tog <= ~hold_tog;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Mostly well-formed notes: restart once the note is over, rarely
        // mid-note; a slice of pure noise on top.
        if ($urandom_range(99) < 10) restart = 1'($urandom);
        else if (tone_frame >= len_reg) restart = ($urandom_range(99) < 50);
        else restart = ($urandom_range(99) < 3);
        send_tick(restart, 1'b0, '0);
        // Pause the sender until everything has come out, then resume.
        if (ph == 6 && n == PHASE_ITEMS / 2) drain_frames();
      end
    end

    // Drain, then watch a while longer for stray frames.
    drain_frames();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d ticks over %0d register settings in %0d cycles:",
             tick_cnt, setting_cnt, cycle_count);
    $display("  %0d tone frames, %0d silent frames, %0d note ends, %0d mismatches",
             tone_cnt, silent_cnt, note_end_cnt, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/stg_pkg.sv
rtl/core/stg_if.sv
rtl/core/stg_mul.sv
rtl/core/stg_div.sv
rtl/core/sine_tone_generator_with_fade.sv
tb/testbench.sv
